[rtl/srvpb_pkg.sv]
// Shared types and constants of the servo record and playback block.
package srvpb_pkg;

  // Transaction kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_BUTTON    = 2'd1,
    KIND_PLAY_TICK = 2'd2,
    KIND_US_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_MANUAL   = 2'd0,
    MODE_RECORD   = 2'd1,
    MODE_PLAYBACK = 2'd2
  } mode_t;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned PULSE_W  = 11;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned PERIOD_W = 16;

  localparam logic [PULSE_W-1:0]  PULSE_RESET  = 11'd1500;
  localparam logic [PULSE_W-1:0]  PULSE_MIN    = 11'd1000;
  localparam logic [PULSE_W-1:0]  PULSE_MID    = 11'd1500;
  localparam logic [PULSE_W-1:0]  PULSE_MAX    = 11'd2000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20000;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 9'd511;

  // Deadband limits: readings from DB_LO up to DB_HI - 1 give the centre pulse.
  localparam logic [SAMPLE_W-1:0] DB_LO = 12'd1948;
  localparam logic [SAMPLE_W-1:0] DB_HI = 12'd2147;

  // Scaled reciprocals, rounded up, for floor(x * 500 / 1947) and floor(x * 500 / 1948).
  // Exact for x up to 1948 with this shift.
  localparam int unsigned MAP_SHIFT = 24;
  localparam int unsigned MUL_W     = 23;
  localparam logic [MUL_W-1:0] MAP_MUL_LO =
    MUL_W'(((64'd1 << MAP_SHIFT) * 64'd500 + 64'd1946) / 64'd1947);
  localparam logic [MUL_W-1:0] MAP_MUL_HI =
    MUL_W'(((64'd1 << MAP_SHIFT) * 64'd500 + 64'd1947) / 64'd1948);

  // Per-transaction control handed from the sequencer to the output stage.
  typedef struct packed {
    logic                 upd_pulse;
    logic                 from_store;
    logic                 store_hit;
    logic                 us_tick;
    mode_t                mode;
    logic [COUNT_W-1:0]   count;
  } item_ctl_t;

endpackage

[rtl/srvpb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srvpb_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/srvpb_pulse_map.sv]
// Sensor reading to pulse width mapping with one reciprocal multiplier.
module srvpb_pulse_map (
  input  logic [srvpb_pkg::SAMPLE_W-1:0] value,
  output logic [srvpb_pkg::PULSE_W-1:0]  pulse
);

  logic                                                    below;
  logic                                                    above;
  logic [srvpb_pkg::SAMPLE_W-1:0]                          operand;
  logic [srvpb_pkg::MUL_W-1:0]                             mul;
  logic [srvpb_pkg::SAMPLE_W+srvpb_pkg::MUL_W-1:0]         prod;
  logic [srvpb_pkg::PULSE_W-1:0]                           quot;

  always_comb begin
    below   = value < srvpb_pkg::DB_LO;
    above   = value >= srvpb_pkg::DB_HI;
    operand = below ? value : (value - srvpb_pkg::DB_HI);
    mul     = below ? srvpb_pkg::MAP_MUL_LO : srvpb_pkg::MAP_MUL_HI;
    prod    = (srvpb_pkg::SAMPLE_W + srvpb_pkg::MUL_W)'(operand) *
              (srvpb_pkg::SAMPLE_W + srvpb_pkg::MUL_W)'(mul);
    quot    = srvpb_pkg::PULSE_W'(prod >> srvpb_pkg::MAP_SHIFT);
    if (below) begin
      pulse = srvpb_pkg::PULSE_MIN + quot;
    end else if (above) begin
      pulse = srvpb_pkg::PULSE_MID + quot;
    end else begin
      pulse = srvpb_pkg::PULSE_MID;
    end
  end

endmodule

[rtl/srvpb_seq_ctrl.sv]
// Mode sequencer and store addressing: record writes, playback reads, fill mark.
module srvpb_seq_ctrl #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  srvpb_pkg::kind_t                  kind,
  input  logic [srvpb_pkg::SAMPLE_W-1:0]    sample,
  output logic                              ram_we,
  output logic [$clog2(DEPTH)-1:0]          ram_waddr,
  output logic [srvpb_pkg::SAMPLE_W-1:0]    ram_wdata,
  output logic                              ram_re,
  output logic [$clog2(DEPTH)-1:0]          ram_raddr,
  output srvpb_pkg::item_ctl_t              item
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned RIW = $clog2(DEPTH + 1);

  srvpb_pkg::mode_t mode_r, mode_nxt;
  logic [RIW-1:0]   rec_idx_r, rec_idx_nxt;
  logic [AW-1:0]    play_idx_r, play_idx_nxt;
  // Entries below the fill mark have been written since reset; the rest read as zero.
  logic [RIW-1:0]   fill_r, fill_nxt;
  logic             rec_ok;
  logic             play_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= srvpb_pkg::MODE_MANUAL;
      rec_idx_r  <= '0;
      play_idx_r <= '0;
      fill_r     <= '0;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      rec_idx_r  <= rec_idx_nxt;
      play_idx_r <= play_idx_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    rec_idx_nxt  = rec_idx_r;
    play_idx_nxt = play_idx_r;
    fill_nxt     = fill_r;
    rec_ok       = 1'b0;
    play_ok      = 1'b0;
    item.upd_pulse  = 1'b0;
    item.from_store = 1'b0;
    item.store_hit  = 32'(play_idx_r) < 32'(fill_r);
    item.us_tick    = 1'b0;

    unique case (kind)
      srvpb_pkg::KIND_SAMPLE: begin
        item.upd_pulse = mode_r != srvpb_pkg::MODE_PLAYBACK;
        rec_ok = (mode_r == srvpb_pkg::MODE_RECORD) && (rec_idx_r < RIW'(DEPTH));
        if (rec_ok) begin
          rec_idx_nxt = rec_idx_r + RIW'(1);
          if (rec_idx_nxt > fill_r) begin
            fill_nxt = rec_idx_nxt;
          end
        end
      end
      srvpb_pkg::KIND_BUTTON: begin
        unique case (mode_r)
          srvpb_pkg::MODE_MANUAL: begin
            mode_nxt     = srvpb_pkg::MODE_RECORD;
            rec_idx_nxt  = '0;
            play_idx_nxt = '0;
          end
          srvpb_pkg::MODE_RECORD: begin
            mode_nxt     = srvpb_pkg::MODE_PLAYBACK;
            play_idx_nxt = '0;
          end
          srvpb_pkg::MODE_PLAYBACK: begin
            mode_nxt = srvpb_pkg::MODE_MANUAL;
          end
          default: begin
            mode_nxt = srvpb_pkg::MODE_MANUAL;
          end
        endcase
      end
      srvpb_pkg::KIND_PLAY_TICK: begin
        play_ok = mode_r == srvpb_pkg::MODE_PLAYBACK;
        item.upd_pulse  = play_ok;
        item.from_store = 1'b1;
        if (play_ok) begin
          play_idx_nxt = (play_idx_r == AW'(DEPTH - 1)) ? '0 : play_idx_r + AW'(1);
        end
      end
      srvpb_pkg::KIND_US_TICK: begin
        item.us_tick = 1'b1;
      end
    endcase

    item.mode  = mode_nxt;
    item.count = (32'(rec_idx_nxt) > 32'(srvpb_pkg::COUNT_MAX)) ?
                 srvpb_pkg::COUNT_MAX : srvpb_pkg::COUNT_W'(rec_idx_nxt);
  end

  assign ram_we    = acc && rec_ok;
  assign ram_waddr = rec_idx_r[AW-1:0];
  assign ram_wdata = sample;
  assign ram_re    = acc && play_ok;
  assign ram_raddr = play_idx_r;

`ifndef SYNTHESIS
  a_rec_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rec_idx_r) <= DEPTH)
    else $error("record index beyond store depth");

  a_fill_covers_rec: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r >= rec_idx_r)
    else $error("fill mark below record index");

  a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (rec_idx_r == $past(rec_idx_r) + RIW'(1)))
    else $error("store write did not advance the record index");
`endif

endmodule

[rtl/servo_pwm_record_playback_top.sv]
// Top level of the servo pulse generator with sample record and playback.
//
//   Channel  Direction  Payload
//   in_      slave      tuser[1:0] kind; tdata[11:0] sample
//   out_     master     tdata: servo_pin, pulse_width_us, mode, record_led, recorded_count
//   cfg_     write      wr_data[15:0] frame_period_us
//
// One transaction is accepted per cycle unless the output stalls; each result is registered.
// The store RAM is read at acceptance and its data is mapped in the second stage, where the
// pulse width, frame counter and pin are updated in transaction order.
// Reset is synchronous; the store needs no clearing pass, as a fill mark makes unwritten
// entries read as zero. A stall on the output holds one result and one transaction in flight.
module servo_pwm_record_playback_top #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample, zero padded
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] servo_pin, [11:1] pulse_width_us, [13:12] mode, [14] record_led,
  // [23:15] recorded_count
  output logic [23:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                                  in_acc;
  srvpb_pkg::item_ctl_t                  item;
  logic                                  ram_we;
  logic [AW-1:0]                         ram_waddr;
  logic [srvpb_pkg::SAMPLE_W-1:0]        ram_wdata;
  logic                                  ram_re;
  logic [AW-1:0]                         ram_raddr;
  logic [srvpb_pkg::SAMPLE_W-1:0]        ram_rdata;

  logic                                  s1_valid_r;
  srvpb_pkg::item_ctl_t                  s1_item_r;
  logic [srvpb_pkg::SAMPLE_W-1:0]        s1_sample_r;
  logic                                  s1_adv;

  logic [srvpb_pkg::PERIOD_W-1:0]        period_r;
  logic [srvpb_pkg::PULSE_W-1:0]         pulse_r, pulse_nxt;
  logic [srvpb_pkg::PERIOD_W-1:0]        frame_r, frame_nxt, frame_inc;
  logic                                  pin_r, pin_nxt;
  logic [srvpb_pkg::SAMPLE_W-1:0]        map_in;
  logic [srvpb_pkg::PULSE_W-1:0]         map_out;

  logic                                  out_valid_r;
  logic [23:0]                           out_data_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  srvpb_seq_ctrl #(
    .DEPTH (DEPTH)
  ) u_seq_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .kind      (srvpb_pkg::kind_t'(in_tuser)),
    .sample    (in_tdata[11:0]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .item      (item)
  );

  srvpb_ram #(
    .WIDTH (srvpb_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The RAM output only changes on a new read, which needs the second stage to move on.
  always_comb begin
    if (s1_item_r.from_store) begin
      map_in = s1_item_r.store_hit ? ram_rdata : '0;
    end else begin
      map_in = s1_sample_r;
    end
  end

  srvpb_pulse_map u_pulse_map (
    .value (map_in),
    .pulse (map_out)
  );

  always_comb begin
    pulse_nxt = s1_item_r.upd_pulse ? map_out : pulse_r;
    frame_inc = frame_r + srvpb_pkg::PERIOD_W'(1);
    frame_nxt = frame_r;
    pin_nxt   = pin_r;
    if (s1_item_r.us_tick) begin
      if (frame_inc >= period_r) begin
        frame_nxt = '0;
        pin_nxt   = 1'b1;
      end else begin
        frame_nxt = frame_inc;
        if (frame_inc == srvpb_pkg::PERIOD_W'(pulse_r)) begin
          pin_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= srvpb_pkg::PERIOD_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pulse_r     <= srvpb_pkg::PULSE_RESET;
      frame_r     <= '0;
      pin_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        pulse_r     <= pulse_nxt;
        frame_r     <= frame_nxt;
        pin_r       <= pin_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r   <= item;
      s1_sample_r <= in_tdata[11:0];
    end
    if (s1_adv) begin
      out_data_r <= {s1_item_r.count,
                     s1_item_r.mode == srvpb_pkg::MODE_RECORD,
                     s1_item_r.mode,
                     pulse_nxt,
                     pin_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_accept_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction did not enter the second stage");

  a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("stalled transaction lost from the second stage");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r >= srvpb_pkg::PULSE_MIN && pulse_r <= srvpb_pkg::PULSE_MAX)
    else $error("pulse width out of range");
`endif

endmodule

[test/servo_pwm_record_playback_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the servo pulse generator with sample record and playback.
module servo_pwm_record_playback_top_tb;
  import srvpb_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned SPAN_LO     = 1947;
  localparam int unsigned SPAN_HI     = 1948;
  localparam int unsigned PULSE_SWING = 500;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned MAX_PRINTED = 100;
  localparam logic [PERIOD_W-1:0] FRAME_MIN = 16'd1000;
  localparam logic [PERIOD_W-1:0] FRAME_MAX = 16'hFFFF;

  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] sample;
  } servo_cmd_t;

  typedef struct packed {
    logic                pin;
    logic [PULSE_W-1:0]  pulse;
    mode_t               mode;
    logic                led;
    logic [COUNT_W-1:0]  count;
  } servo_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  servo_pwm_record_playback_top #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow of the servo state, advanced once per accepted input transaction.
  mode_t               srv_mode;
  logic [PULSE_W-1:0]  srv_pulse;
  logic [SAMPLE_W-1:0] srv_store [STORE_DEPTH];
  int unsigned         srv_rec_idx;
  int unsigned         srv_play_idx;
  logic [PERIOD_W-1:0] srv_frame_cnt;
  logic [PERIOD_W-1:0] srv_frame_len;
  logic                srv_pin;

  servo_cmd_t    pending_cmds[$];
  servo_status_t expected_status[$];

  mode_t       gen_mode;
  int unsigned gen_content;
  int unsigned errors = 0;
  int unsigned results_seen = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [PULSE_W-1:0] pulse_for(logic [SAMPLE_W-1:0] v);
    int unsigned x;
    x = v;
    if (x >= DB_LO && x < DB_HI) return PULSE_MID;
    if (x < DB_LO) return PULSE_W'(PULSE_MIN + (x * PULSE_SWING) / SPAN_LO);
    return PULSE_W'(PULSE_MID + ((x - DB_HI) * PULSE_SWING) / SPAN_HI);
  endfunction

  task automatic apply_cmd(servo_cmd_t c);
    servo_status_t st;
    case (c.kind)
      KIND_SAMPLE: begin
        if (srv_mode != MODE_PLAYBACK) srv_pulse = pulse_for(c.sample);
        if (srv_mode == MODE_RECORD && srv_rec_idx < STORE_DEPTH) begin
          srv_store[srv_rec_idx] = c.sample;
          srv_rec_idx++;
        end
      end
      KIND_BUTTON: begin
        if (srv_mode == MODE_MANUAL) begin
          srv_mode = MODE_RECORD;
          srv_rec_idx = 0;
          srv_play_idx = 0;
        end else if (srv_mode == MODE_RECORD) begin
          srv_mode = MODE_PLAYBACK;
          srv_play_idx = 0;
        end else begin
          srv_mode = MODE_MANUAL;
        end
      end
      KIND_PLAY_TICK: begin
        // The whole store is replayed, recorded or not.
        if (srv_mode == MODE_PLAYBACK) begin
          if (srv_play_idx >= STORE_DEPTH) srv_play_idx = 0;
          srv_pulse = pulse_for(srv_store[srv_play_idx]);
          srv_play_idx++;
          if (srv_play_idx >= STORE_DEPTH) srv_play_idx = 0;
        end
      end
      default: begin
        srv_frame_cnt = srv_frame_cnt + 1'b1;
        if (srv_frame_cnt >= srv_frame_len) begin
          srv_frame_cnt = '0;
          srv_pin = 1'b1;
        end else if (srv_frame_cnt == PERIOD_W'(srv_pulse)) begin
          srv_pin = 1'b0;
        end
      end
    endcase
    st.pin   = srv_pin;
    st.pulse = srv_pulse;
    st.mode  = srv_mode;
    st.led   = (srv_mode == MODE_RECORD);
    st.count = (srv_rec_idx > COUNT_MAX) ? COUNT_MAX : COUNT_W'(srv_rec_idx);
    expected_status.push_back(st);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (errors < MAX_PRINTED)
      $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Stimulus generation; the generator tracks the mode itself, as only buttons change it.
  task automatic push_cmd(kind_t k, logic [SAMPLE_W-1:0] s);
    servo_cmd_t c;
    c.kind = k;
    c.sample = s;
    pending_cmds.push_back(c);
    if (k != KIND_US_TICK) gen_content++;
    if (k == KIND_BUTTON) begin
      if (gen_mode == MODE_MANUAL) gen_mode = MODE_RECORD;
      else if (gen_mode == MODE_RECORD) gen_mode = MODE_PLAYBACK;
      else gen_mode = MODE_MANUAL;
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    if ($urandom_range(0, 3) != 0) return SAMPLE_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 12'd1;
      2: return DB_LO - 1'b1;
      3: return DB_LO;
      4: return DB_HI - 1'b1;
      5: return DB_HI;
      6: return 12'hFFE;
      default: return 12'hFFF;
    endcase
  endfunction

  task automatic push_ticks(int unsigned n);
    repeat (n) push_cmd(KIND_US_TICK, SAMPLE_W'($urandom));
  endtask

  task automatic goto_mode(mode_t m);
    while (gen_mode != m) push_cmd(KIND_BUTTON, SAMPLE_W'($urandom));
  endtask

  task automatic build_random_phase(int unsigned content_goal);
    int unsigned n;
    gen_content = 0;
    while (gen_content < content_goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          goto_mode(MODE_RECORD);
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(STORE_DEPTH, STORE_DEPTH + 40)
                                         : $urandom_range(1, 40);
          repeat (n) begin
            push_cmd(KIND_SAMPLE, rand_sample());
            if ($urandom_range(0, 3) == 0) push_ticks($urandom_range(1, 8));
          end
        end
        3, 4: begin
          goto_mode(MODE_PLAYBACK);
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(STORE_DEPTH, STORE_DEPTH + 60)
                                         : $urandom_range(1, 40);
          repeat (n) begin
            push_cmd(KIND_PLAY_TICK, SAMPLE_W'($urandom));
            if ($urandom_range(0, 3) == 0) push_ticks($urandom_range(1, 8));
            if ($urandom_range(0, 15) == 0) push_cmd(KIND_SAMPLE, rand_sample());
          end
        end
        5: begin
          goto_mode(MODE_MANUAL);
          repeat ($urandom_range(1, 20)) begin
            push_cmd(KIND_SAMPLE, rand_sample());
            if ($urandom_range(0, 1) == 0) push_ticks($urandom_range(1, 8));
          end
        end
        6: begin
          repeat ($urandom_range(1, 20)) push_cmd(kind_t'($urandom_range(0, 3)), rand_sample());
        end
        default: begin
          // Now and then a run long enough to span a whole frame.
          if ($urandom_range(0, 2) == 0) push_ticks(int'(srv_frame_len) + $urandom_range(0, 100));
          else push_ticks($urandom_range(1, 200));
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] p);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    srv_frame_len = p;
  endtask

  // Sender: bursts of random length with random gaps after them.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : drive_cmds
    servo_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        c.kind = kind_t'(in_tuser);
        c.sample = in_tdata[SAMPLE_W-1:0];
        apply_cmd(c);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          c = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.kind;
          in_tdata <= {{(16 - SAMPLE_W){1'b0}}, c.sample};
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own pattern of ready runs and stalls, plus two long hold-offs.
  int unsigned ready_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_stage = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ((hold_stage == 0 && results_seen >= 300) ||
                 (hold_stage == 1 && results_seen >= 6000)) begin
      out_tready <= 1'b0;
      hold_left <= 400;
      hold_stage <= hold_stage + 1;
    end else if (ready_left != 0) begin
      out_tready <= 1'b1;
      ready_left <= ready_left - 1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      ready_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
      stall_left <= $urandom_range(1, 5);
    end
  end

  always @(posedge clk) begin : check_status
    servo_status_t got;
    servo_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pin   = out_tdata[0];
      got.pulse = out_tdata[11:1];
      got.mode  = mode_t'(out_tdata[13:12]);
      got.led   = out_tdata[14];
      got.count = out_tdata[23:15];
      results_seen <= results_seen + 1;
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected result, out_tdata", out_tdata, 0);
      end else begin
        want = expected_status.pop_front();
        if (got.pin !== want.pin) report_mismatch("servo_pin", got.pin, want.pin);
        if (got.pulse !== want.pulse) report_mismatch("pulse_width_us", got.pulse, want.pulse);
        if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
        if (got.led !== want.led) report_mismatch("record_led", got.led, want.led);
        if (got.count !== want.count) report_mismatch("recorded_count", got.count, want.count);
      end
    end
  end

  initial begin
    srv_mode = MODE_MANUAL;
    srv_pulse = PULSE_RESET;
    foreach (srv_store[i]) srv_store[i] = '0;
    srv_rec_idx = 0;
    srv_play_idx = 0;
    srv_frame_cnt = '0;
    srv_frame_len = PERIOD_RESET;
    srv_pin = 1'b0;
    gen_mode = MODE_MANUAL;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Mapping edges in manual mode, then a short record and playback round.
    push_cmd(KIND_SAMPLE, 12'd0);
    push_cmd(KIND_SAMPLE, 12'hFFF);
    push_cmd(KIND_SAMPLE, DB_LO - 1'b1);
    push_cmd(KIND_SAMPLE, DB_LO);
    push_cmd(KIND_SAMPLE, DB_HI - 1'b1);
    push_cmd(KIND_SAMPLE, DB_HI);
    push_cmd(KIND_SAMPLE, 12'hAAA);
    push_cmd(KIND_SAMPLE, 12'h555);
    push_cmd(KIND_BUTTON, 12'hFFF);
    push_cmd(KIND_SAMPLE, 12'd0);
    push_cmd(KIND_SAMPLE, 12'hFFF);
    push_cmd(KIND_SAMPLE, DB_HI - 1'b1);
    push_cmd(KIND_BUTTON, 12'd0);
    push_cmd(KIND_SAMPLE, 12'd1000);
    push_cmd(KIND_PLAY_TICK, 12'hFFF);
    push_cmd(KIND_PLAY_TICK, 12'd0);
    push_cmd(KIND_PLAY_TICK, 12'h5A5);
    push_cmd(KIND_PLAY_TICK, 12'hA5A);
    push_cmd(KIND_BUTTON, 12'h123);
    push_cmd(KIND_PLAY_TICK, 12'hFFF);
    push_cmd(KIND_US_TICK, 12'hFFF);
    push_cmd(KIND_US_TICK, 12'd0);
    push_cmd(KIND_US_TICK, 12'h800);

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph == 0) write_period(FRAME_MIN);
      else if (ph == 1) write_period(PULSE_MAX + 1'b1);
      else write_period(PERIOD_W'($urandom_range(FRAME_MIN + 1, 2600)));
      if (ph == 0) begin
        // Fill the store beyond its end, then play it round more than once.
        goto_mode(MODE_MANUAL);
        goto_mode(MODE_RECORD);
        repeat (STORE_DEPTH + 8) push_cmd(KIND_SAMPLE, rand_sample());
        goto_mode(MODE_PLAYBACK);
        repeat (STORE_DEPTH + 8) push_cmd(KIND_PLAY_TICK, SAMPLE_W'($urandom));
      end
      build_random_phase(PHASE_ITEMS);
    end

    // The longest frame, run through at least one full wrap.
    wait_idle();
    write_period(FRAME_MAX);
    goto_mode(MODE_MANUAL);
    push_cmd(KIND_SAMPLE, rand_sample());
    repeat (int'(FRAME_MAX) + 300) begin
      if ($urandom_range(0, 499) == 0) push_cmd(KIND_SAMPLE, rand_sample());
      else push_cmd(KIND_US_TICK, SAMPLE_W'($urandom));
    end

    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_status.size() != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
